/* src/iirf4_pkg.sv */
// Shared types and constants of the fourth-order IIR filter.
package iirf4_pkg;

  localparam int CoefBits    = 24;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 2 * CoefBits;
  localparam int StepBits    = 4;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_B0_B1 = 3'd0,
    CFG_B2_B3 = 3'd1,
    CFG_B4    = 3'd2,
    CFG_A1_A2 = 3'd3,
    CFG_A3_A4 = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    C_B0 = 4'd0,
    C_B1 = 4'd1,
    C_B2 = 4'd2,
    C_B3 = 4'd3,
    C_B4 = 4'd4,
    C_A1 = 4'd5,
    C_A2 = 4'd6,
    C_A3 = 4'd7,
    C_A4 = 4'd8
  } coef_e;

  typedef enum logic [1:0] {
    SRC_IN = 2'd0,
    SRC_X  = 2'd1,
    SRC_Y  = 2'd2
  } mul_src_e;

  typedef enum logic [2:0] {
    OP_NOP       = 3'd0,
    OP_ADD_STATE = 3'd1,
    OP_ADD_ZERO  = 3'd2,
    OP_ROUND     = 3'd3,
    OP_SUB_STORE = 3'd4
  } acc_op_e;

  typedef struct packed {
    logic     load_x;
    logic     mul_en;
    coef_e    coef;
    mul_src_e src;
    acc_op_e  op;
    logic [1:0] sidx;
  } cmd_t;

endpackage

/* src/iirf4_ifs.sv */
// Handshake interfaces for the sample, result and configuration channels.
interface iirf4_smp_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface iirf4_res_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          clipped;
  modport source (output valid, output filtered, output clipped, input ready);
  modport sink (input valid, input filtered, input clipped, output ready);
endinterface

interface iirf4_cfg_if ();
  logic                                valid;
  logic                                ready;
  logic [iirf4_pkg::CfgIdxBits-1:0]    index;
  logic [iirf4_pkg::CfgDataBits-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/iirf4_datapath.sv */
// Datapath: coefficient registers, shared multiplier, accumulator and delay state.
module iirf4_datapath #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 20,
  parameter int STATE_BITS     = 44
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  iirf4_pkg::cmd_t                      cmd_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  input  logic                                 cfg_valid_i,
  input  logic [iirf4_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [iirf4_pkg::CfgDataBits-1:0]    cfg_data_i,
  output logic signed [SAMPLE_BITS-1:0]        filtered_o,
  output logic                                 clipped_o
);

  localparam int CB = iirf4_pkg::CoefBits;
  localparam int DW = iirf4_pkg::CfgDataBits;
  localparam int SB = SAMPLE_BITS;
  localparam int SW = STATE_BITS;
  localparam int PW = CB + SB;
  localparam int WW = ((SW > PW) ? SW : PW) + 2;

  localparam logic [DW-1:0] B01_RST = {{(DW-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;
  localparam logic signed [WW-1:0] SMAX = {{(WW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [WW-1:0] SMIN = {{(WW-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [WW-1:0] HALF =
    {{(WW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [SW-1:0] YMAX = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [SW-1:0] YMIN = {{(SW-SB+1){1'b1}}, {(SB-1){1'b0}}};

  logic [DW-1:0] b01_q, b23_q, a12_q, a34_q;
  logic [CB-1:0] b4_q;

  logic signed [SB-1:0] x_q, y_q;
  logic                 clip_q;
  logic signed [PW-1:0] prod_q;
  logic signed [SW-1:0] acc_q;
  logic signed [SW-1:0] st_q [4];

  logic signed [CB-1:0] coef;
  logic signed [SB-1:0] opnd;
  logic signed [WW-1:0] prod_w, acc_w, st_w, add_sum, sub_sum, rnd_sum;
  logic signed [SW-1:0] prod_c, add_c, sub_c, rnd_c, rnd_sh;
  logic signed [SB-1:0] y_d;
  logic                 clip_d;

  function automatic logic signed [SW-1:0] clamp_state(input logic signed [WW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SMAX) begin
      r = SMAX[SW-1:0];
    end else if (v < SMIN) begin
      r = SMIN[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b01_q <= B01_RST;
      b23_q <= '0;
      b4_q  <= '0;
      a12_q <= '0;
      a34_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        iirf4_pkg::CFG_B0_B1: b01_q <= cfg_data_i;
        iirf4_pkg::CFG_B2_B3: b23_q <= cfg_data_i;
        iirf4_pkg::CFG_B4:    b4_q  <= cfg_data_i[CB-1:0];
        iirf4_pkg::CFG_A1_A2: a12_q <= cfg_data_i;
        iirf4_pkg::CFG_A3_A4: a34_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.coef)
      iirf4_pkg::C_B0: coef = b01_q[CB-1:0];
      iirf4_pkg::C_B1: coef = b01_q[2*CB-1:CB];
      iirf4_pkg::C_B2: coef = b23_q[CB-1:0];
      iirf4_pkg::C_B3: coef = b23_q[2*CB-1:CB];
      iirf4_pkg::C_B4: coef = b4_q;
      iirf4_pkg::C_A1: coef = a12_q[CB-1:0];
      iirf4_pkg::C_A2: coef = a12_q[2*CB-1:CB];
      iirf4_pkg::C_A3: coef = a34_q[CB-1:0];
      iirf4_pkg::C_A4: coef = a34_q[2*CB-1:CB];
      default:         coef = '0;
    endcase
    unique case (cmd_i.src)
      iirf4_pkg::SRC_IN: opnd = sample_i;
      iirf4_pkg::SRC_X:  opnd = x_q;
      iirf4_pkg::SRC_Y:  opnd = y_q;
      default:           opnd = '0;
    endcase
  end

  always_comb begin
    prod_w  = {{(WW-PW){prod_q[PW-1]}}, prod_q};
    prod_c  = clamp_state(prod_w);
    acc_w   = {{(WW-SW){acc_q[SW-1]}}, acc_q};
    st_w    = (cmd_i.op == iirf4_pkg::OP_ADD_ZERO) ? '0
            : {{(WW-SW){st_q[cmd_i.sidx][SW-1]}}, st_q[cmd_i.sidx]};
    add_sum = {{(WW-SW){prod_c[SW-1]}}, prod_c} + st_w;
    add_c   = clamp_state(add_sum);
    sub_sum = acc_w - prod_w;
    sub_c   = clamp_state(sub_sum);
    rnd_sum = acc_w + HALF;
    rnd_c   = clamp_state(rnd_sum);
    rnd_sh  = rnd_c >>> COEF_FRAC_BITS;
    if (rnd_sh > YMAX) begin
      y_d    = YMAX[SB-1:0];
      clip_d = 1'b1;
    end else if (rnd_sh < YMIN) begin
      y_d    = YMIN[SB-1:0];
      clip_d = 1'b1;
    end else begin
      y_d    = rnd_sh[SB-1:0];
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= sample_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= coef * opnd;
    end
    if (cmd_i.op == iirf4_pkg::OP_ADD_STATE || cmd_i.op == iirf4_pkg::OP_ADD_ZERO) begin
      acc_q <= add_c;
    end
    if (cmd_i.op == iirf4_pkg::OP_ROUND) begin
      y_q    <= y_d;
      clip_q <= clip_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        st_q[i] <= '0;
      end
    end else if (cmd_i.op == iirf4_pkg::OP_SUB_STORE) begin
      st_q[cmd_i.sidx] <= sub_c;
    end
  end

  assign filtered_o = y_q;
  assign clipped_o  = clip_q;

endmodule

/* src/iirf4_ctrl.sv */
// Controller: sequences the nine products and the delay updates of one sample.
module iirf4_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output iirf4_pkg::cmd_t cmd_o
);

  localparam int SBW = iirf4_pkg::StepBits;
  localparam logic [SBW-1:0] STEP_ACC0  = SBW'(1);
  localparam logic [SBW-1:0] STEP_ROUND = SBW'(2);
  localparam logic [SBW-1:0] STEP_ACC1  = SBW'(3);
  localparam logic [SBW-1:0] STEP_SUB0  = SBW'(4);
  localparam logic [SBW-1:0] STEP_ACC2  = SBW'(5);
  localparam logic [SBW-1:0] STEP_SUB1  = SBW'(6);
  localparam logic [SBW-1:0] STEP_ACC3  = SBW'(7);
  localparam logic [SBW-1:0] STEP_SUB2  = SBW'(8);
  localparam logic [SBW-1:0] STEP_ACC4  = SBW'(9);
  localparam logic [SBW-1:0] STEP_LAST  = SBW'(10);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [SBW-1:0]  step_q, step_d;
  logic            out_valid_q, out_valid_d;
  logic            stall;
  iirf4_pkg::cmd_t cmd;

  assign stall = out_valid_q && !out_ready_i;

  always_comb begin
    cmd         = '{load_x: 1'b0, mul_en: 1'b0, coef: iirf4_pkg::C_B0,
                    src: iirf4_pkg::SRC_X, op: iirf4_pkg::OP_NOP, sidx: 2'd0};
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load_x = 1'b1;
          cmd.mul_en = 1'b1;
          cmd.coef   = iirf4_pkg::C_B0;
          cmd.src    = iirf4_pkg::SRC_IN;
          state_d    = ST_RUN;
          step_d     = STEP_ACC0;
        end
      end
      ST_RUN: begin
        step_d = step_q + SBW'(1);
        unique case (step_q)
          STEP_ACC0: begin
            cmd.op = iirf4_pkg::OP_ADD_STATE; cmd.sidx = 2'd0;
            cmd.mul_en = 1'b1; cmd.coef = iirf4_pkg::C_B1;
          end
          STEP_ROUND: begin
            if (stall) begin
              step_d = step_q;
            end else begin
              cmd.op      = iirf4_pkg::OP_ROUND;
              out_valid_d = 1'b1;
            end
          end
          STEP_ACC1: begin
            cmd.op = iirf4_pkg::OP_ADD_STATE; cmd.sidx = 2'd1;
            cmd.mul_en = 1'b1; cmd.coef = iirf4_pkg::C_A1; cmd.src = iirf4_pkg::SRC_Y;
          end
          STEP_SUB0: begin
            cmd.op = iirf4_pkg::OP_SUB_STORE; cmd.sidx = 2'd0;
            cmd.mul_en = 1'b1; cmd.coef = iirf4_pkg::C_B2;
          end
          STEP_ACC2: begin
            cmd.op = iirf4_pkg::OP_ADD_STATE; cmd.sidx = 2'd2;
            cmd.mul_en = 1'b1; cmd.coef = iirf4_pkg::C_A2; cmd.src = iirf4_pkg::SRC_Y;
          end
          STEP_SUB1: begin
            cmd.op = iirf4_pkg::OP_SUB_STORE; cmd.sidx = 2'd1;
            cmd.mul_en = 1'b1; cmd.coef = iirf4_pkg::C_B3;
          end
          STEP_ACC3: begin
            cmd.op = iirf4_pkg::OP_ADD_STATE; cmd.sidx = 2'd3;
            cmd.mul_en = 1'b1; cmd.coef = iirf4_pkg::C_A3; cmd.src = iirf4_pkg::SRC_Y;
          end
          STEP_SUB2: begin
            cmd.op = iirf4_pkg::OP_SUB_STORE; cmd.sidx = 2'd2;
            cmd.mul_en = 1'b1; cmd.coef = iirf4_pkg::C_B4;
          end
          STEP_ACC4: begin
            cmd.op = iirf4_pkg::OP_ADD_ZERO;
            cmd.mul_en = 1'b1; cmd.coef = iirf4_pkg::C_A4; cmd.src = iirf4_pkg::SRC_Y;
          end
          STEP_LAST: begin
            cmd.op = iirf4_pkg::OP_SUB_STORE; cmd.sidx = 2'd3;
            state_d = ST_IDLE;
            step_d  = '0;
          end
          default: begin
            state_d = ST_IDLE;
            step_d  = '0;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_LAST)
    else $error("step counter out of range");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_RUN && step_q == STEP_ACC0))
    else $error("accepted sample did not start a run");

  a_round_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == iirf4_pkg::OP_ROUND) |=> out_valid_q)
    else $error("rounded result not presented");

  a_round_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q == STEP_ROUND && stall) |=> (step_q == STEP_ROUND))
    else $error("result overwritten while receiver stalls");

endmodule

/* src/iir_fourth_order_filter.sv */
// Fourth-order transposed direct form II IIR filter, top level.
//
// Channels: in_i takes one signed sample per transfer, out_o gives one
// filtered sample with a clip flag per input, cfg_i writes the five
// coefficient registers (index 0..4, others ignored; always ready).
// Coefficients are signed Q3.20 by default; a0 is taken as 1.
//
// Sequence: the sample is taken while idle and ten more steps follow, set by
// the single shared multiplier that forms all nine products, with the
// accumulator working on the registered product; no new sample is taken
// until the steps are done. The result is registered onto out_o after the
// rounding step, and the delay updates finish in the steps that follow.
// Stall: if the previous result is still untaken when the new one is ready,
// the sequencer holds at the rounding step until out_o transfers.
// Reset: b0 = 1.0, all other coefficients and the four delays clear to zero,
// so the block passes samples through until configured.
module iir_fourth_order_filter #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 20,
  parameter int STATE_BITS     = 44
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  iirf4_smp_if.sink   in_i,
  iirf4_res_if.source out_o,
  iirf4_cfg_if.sink   cfg_i
);

  iirf4_pkg::cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  iirf4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  iirf4_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .STATE_BITS     (STATE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_i    (in_i.sample),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .filtered_o  (out_o.filtered),
    .clipped_o   (out_o.clipped)
  );

endmodule
